@@ rtl/mrf_pkg.sv @@
// Shared types, constants and the CRC-16 byte update for the Modbus RTU request framer.
// No dependencies.
package mrf_pkg;

  localparam logic       CMD_HEADER        = 1'b0;
  localparam logic       CMD_VALUE         = 1'b1;
  localparam logic [7:0] FN_WRITE_MULTIPLE = 8'h10;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;

  localparam int IDX_W = 4;
  localparam logic [IDX_W-1:0] READ_HDR_LEN  = 4'd6;
  localparam logic [IDX_W-1:0] WRITE_HDR_LEN = 4'd7;
  localparam logic [IDX_W-1:0] VALUE_LEN     = 4'd2;
  localparam logic [IDX_W-1:0] CRC_LEN       = 4'd2;

  typedef struct packed {
    logic        command;
    logic [7:0]  slave_id;
    logic [7:0]  fn_code;
    logic [15:0] start_address;
    logic [6:0]  item_count;
    logic [15:0] register_value;
  } cmd_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_end;
  } tx_word_t;

  // Reflected CRC-16 over one byte, one bit per step.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/modbus_rtu_request_framer.sv @@
// Modbus RTU request framer: turns header and register-value words into a framed byte stream.
// Depends on mrf_pkg for the word types, constants and the CRC byte update.
//
// Usage:
//   The cmd channel takes one word per accepted handshake (valid high, stall low). A header
//   word (command 0) starts a frame: six bytes for a read, seven for write multiple
//   (function 16). Each value word (command 1) of an open write frame adds two bytes. The
//   CRC, low byte first, follows the read header, an empty write header, or the last value.
//   A value word with no write frame open is taken and produces nothing.
//   The tx channel carries one byte per word, with last_of_run on the final byte caused by
//   a command word and frame_end on the final CRC byte.
//   The first byte of a command word passes from the command register into the tx register.
//   Throughput is one byte per cycle while tx is not stalled, set by the byte serializer
//   behind the command register: a value word yields 2 or 4 bytes, a header 7, 8 or 9.
//   The next command word is taken in the cycle its predecessor sends its last byte.
//   Reset clears both channels and any open frame; the CRC returns to 0xFFFF.
//   When tx stalls, the tx word holds, the serializer waits, and cmd stall rises once the
//   command register is occupied.
module modbus_rtu_request_framer (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  mrf_pkg::cmd_word_t cmd_word,
  output logic              tx_valid,
  input  logic              tx_stall,
  output mrf_pkg::tx_word_t  tx_word
);
  import mrf_pkg::*;

  // Committed frame state, updated in word order at acceptance.
  logic       frame_open;
  logic [6:0] remaining;

  // Command register and serializer.
  logic             h_valid;
  logic [IDX_W-1:0] idx;
  logic             h_header;
  logic             h_write;
  logic             h_crc;
  cmd_word_t        h_word;
  logic [15:0]      crc;

  logic             accept;
  logic             adv;
  logic             last;
  logic [IDX_W-1:0] data_len;
  logic [IDX_W-1:0] total;
  logic [7:0]       cur_byte;
  logic             cur_data;
  logic             cur_end;
  logic [15:0]      crc_base;
  logic             is_fn_write;
  logic             ld_crc;
  logic             load;

  always_comb begin
    if (h_header) begin
      data_len = h_write ? WRITE_HDR_LEN : READ_HDR_LEN;
    end else begin
      data_len = VALUE_LEN;
    end
    total = data_len + (h_crc ? CRC_LEN : 4'd0);
    last  = (idx == total - 4'd1);
    adv   = h_valid && (!tx_valid || !tx_stall);

    cur_data = (idx < data_len);
    cur_end  = 1'b0;
    cur_byte = 8'h00;
    if (cur_data) begin
      if (h_header) begin
        unique case (idx)
          4'd0:    cur_byte = h_word.slave_id;
          4'd1:    cur_byte = h_word.fn_code;
          4'd2:    cur_byte = h_word.start_address[15:8];
          4'd3:    cur_byte = h_word.start_address[7:0];
          4'd4:    cur_byte = 8'h00;
          4'd5:    cur_byte = {1'b0, h_word.item_count};
          default: cur_byte = {h_word.item_count, 1'b0};
        endcase
      end else begin
        cur_byte = (idx == 4'd0) ? h_word.register_value[15:8] : h_word.register_value[7:0];
      end
    end else if (idx == data_len) begin
      cur_byte = crc[7:0];
    end else begin
      cur_byte = crc[15:8];
      cur_end  = 1'b1;
    end
    // Each header restarts the CRC on its first byte.
    crc_base = (h_header && idx == 4'd0) ? CRC_INIT : crc;
  end

  assign cmd_stall   = h_valid && !(adv && last);
  assign accept      = cmd_valid && !cmd_stall;
  assign is_fn_write = (cmd_word.fn_code == FN_WRITE_MULTIPLE);

  always_comb begin
    load   = 1'b0;
    ld_crc = 1'b0;
    if (cmd_word.command == CMD_HEADER) begin
      load   = 1'b1;
      ld_crc = !is_fn_write || (cmd_word.item_count == 7'd0);
    end else if (frame_open) begin
      load   = 1'b1;
      ld_crc = (remaining == 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      remaining  <= 7'd0;
      h_valid    <= 1'b0;
      idx        <= '0;
      crc        <= CRC_INIT;
      tx_valid   <= 1'b0;
    end else begin
      if (adv) begin
        tx_valid            <= 1'b1;
        tx_word.out_byte    <= cur_byte;
        tx_word.last_of_run <= last;
        tx_word.frame_end   <= cur_end;
        if (cur_data) begin
          crc <= crc_feed(crc_base, cur_byte);
        end
        // On the final byte a loaded follower takes over the index and valid flag.
        if (!last) begin
          idx <= idx + 4'd1;
        end else if (!(accept && load)) begin
          h_valid <= 1'b0;
        end
      end else if (!tx_stall) begin
        tx_valid <= 1'b0;
      end
      if (accept) begin
        if (cmd_word.command == CMD_HEADER) begin
          frame_open <= is_fn_write && (cmd_word.item_count != 7'd0);
          remaining  <= cmd_word.item_count;
        end else if (frame_open) begin
          remaining <= remaining - 7'd1;
          if (remaining == 7'd1) begin
            frame_open <= 1'b0;
          end
        end
        if (load) begin
          h_valid  <= 1'b1;
          idx      <= '0;
          h_header <= (cmd_word.command == CMD_HEADER);
          h_write  <= is_fn_write;
          h_crc    <= ld_crc;
          h_word   <= cmd_word;
        end
      end
    end
  end

  // A CRC end byte always closes the run of its command word.
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    tx_valid |-> (!tx_word.frame_end || tx_word.last_of_run))
    else $error("frame_end without last_of_run");

  // A new command word only enters while the held one sends its final byte.
  a_accept_on_last: assert property (@(posedge clk) disable iff (rst)
    (accept && h_valid) |-> (adv && last))
    else $error("command register overwritten mid-run");

  // The serializer index stays inside the run length.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    h_valid |-> (idx < total))
    else $error("serializer index out of range");

  // An open write frame always expects at least one more value.
  a_open_count: assert property (@(posedge clk) disable iff (rst)
    frame_open |-> (remaining != 7'd0))
    else $error("open frame with no values remaining");

endmodule
